// ----- hw/rtl/ng5p_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ng5p_pkg
// Shared types and constants for the five-phase noise gate.
// ----------------------------------------------------------------------------
package ng5p_pkg;

    localparam int CH_BITS       = 3;
    localparam int THRESH_BITS   = 16;
    localparam int GAIN_BITS     = 16;
    localparam int GAIN_CNT_BITS = $clog2(GAIN_BITS);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int PHASE_BITS    = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WAIT      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE   = 3'd4;

    localparam logic [PHASE_BITS-1:0] PH_WAIT    = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_ATTACK  = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_ACTIVE  = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_HOLD    = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_RELEASE = 3'd4;

    typedef enum logic [1:0] {
        OM_PASS  = 2'd0,
        OM_ZERO  = 2'd1,
        OM_SCALE = 2'd2
    } t_out_mode;

endpackage

// ----- hw/rtl/ng5p_gain_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ng5p_gain_div
// Restoring divider that forms a Q0.16 gain floor((num << 16) / den), one
// quotient bit per cycle, for num < den.
// ----------------------------------------------------------------------------
module ng5p_gain_div import ng5p_pkg::*; #(
    parameter int COUNT_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COUNT_BITS-1:0] i_num,
    input  logic [COUNT_BITS-1:0] i_den,
    output logic                  o_done,
    output logic [GAIN_BITS-1:0]  o_quot
);

    logic [COUNT_BITS-1:0]    r_rem;
    logic [COUNT_BITS-1:0]    r_den;
    logic [GAIN_BITS-1:0]     r_quot;
    logic [GAIN_CNT_BITS-1:0] r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [COUNT_BITS:0]      trial;
    logic [COUNT_BITS:0]      diff;
    logic                     fits;

    assign trial = {r_rem, 1'b0};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= GAIN_CNT_BITS'(GAIN_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            r_quot <= {r_quot[GAIN_BITS-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- hw/rtl/noise_gate_five_phase.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_gate_five_phase
// Per-channel noise gate with wait, attack, active, hold and release phases.
// ----------------------------------------------------------------------------
// Passed or muted samples go through the load and decide states to the output
// state; ramped samples also go through the divide and multiply states.
// Throughput: one sample at a time; the next is accepted the cycle after the
// result transaction. The ramp gain comes from a 16-step serial divider.
// Reset: synchronous; every channel returns to waiting with a zero count and
// the configuration registers take their reset values.
module noise_gate_five_phase import ng5p_pkg::*; #(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [CH_BITS-1:0]            i_channel,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic [PHASE_BITS-1:0]         o_gate_phase,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data
);

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMPW   = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
    localparam int PW     = SAMPLE_BITS + GAIN_BITS + 1;
    localparam logic [31:0] CH_LIMIT = CHANNELS;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_DIV    = 6'b001000,
        S_MUL    = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [THRESH_BITS-1:0] r_threshold;
    logic [COUNT_BITS-1:0]  r_wait, r_attack, r_hold, r_release;

    logic [PHASE_BITS-1:0]  r_phase [CHANNELS];
    logic [COUNT_BITS-1:0]  r_count [CHANNELS];

    logic [CH_BITS-1:0]          r_ch;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                        r_below;
    logic                        r_ge;
    logic [PHASE_BITS-1:0]       r_ph;
    logic [COUNT_BITS-1:0]       r_cnt;
    logic [COUNT_BITS-1:0]       r_n;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic [PHASE_BITS-1:0]       r_gph;

    logic [IDX_W-1:0]       idx;
    logic                   in_range;
    logic [SAMPLE_BITS-1:0] mag;
    logic [COUNT_BITS-1:0]  limit;
    logic [COUNT_BITS-1:0]  cnt_next;

    logic                  d_we;
    logic [PHASE_BITS-1:0] d_ph;
    logic [COUNT_BITS-1:0] d_cnt;
    t_out_mode             d_mode;
    logic [COUNT_BITS-1:0] d_num;
    logic [COUNT_BITS-1:0] d_den;

    logic                  div_start;
    logic                  div_done;
    logic [GAIN_BITS-1:0]  div_quot;
    logic signed [PW-1:0]  prod;

    assign idx      = IDX_W'(r_ch);
    assign in_range = (32'(r_ch) < CH_LIMIT);
    assign mag      = r_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_sample) : r_sample;
    assign cnt_next = r_count[idx] + 1'b1;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_wait      <= '0;
            r_attack    <= COUNT_BITS'(1);
            r_hold      <= '0;
            r_release   <= COUNT_BITS'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THRESH_BITS-1:0];
                CFG_WAIT:      r_wait      <= i_cfg_data[COUNT_BITS-1:0];
                CFG_ATTACK:    r_attack    <= i_cfg_data[COUNT_BITS-1:0];
                CFG_HOLD:      r_hold      <= i_cfg_data[COUNT_BITS-1:0];
                CFG_RELEASE:   r_release   <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (r_phase[idx])
            PH_WAIT:    limit = r_wait;
            PH_ATTACK:  limit = r_attack;
            PH_HOLD:    limit = r_hold;
            PH_RELEASE: limit = r_release;
            default:    limit = '0;
        endcase
    end

    always_comb begin
        d_we   = 1'b0;
        d_ph   = r_ph;
        d_cnt  = r_cnt;
        d_mode = OM_PASS;
        d_num  = r_n;
        d_den  = r_release;
        unique case (r_ph)
            PH_WAIT: begin
                d_we = 1'b1;
                if (r_below) begin
                    if (r_ge) begin
                        d_cnt = '0;
                        d_ph  = PH_ATTACK;
                    end else begin
                        d_cnt = r_n;
                    end
                end else begin
                    d_cnt = '0;
                end
            end
            PH_ATTACK: begin
                d_we = 1'b1;
                if (r_below) begin
                    if (r_ge) begin
                        d_cnt  = '0;
                        d_ph   = PH_ACTIVE;
                        d_mode = OM_ZERO;
                    end else begin
                        d_cnt  = r_n;
                        d_mode = OM_SCALE;
                        d_num  = r_attack - r_n;
                        d_den  = r_attack;
                    end
                end else begin
                    d_cnt = '0;
                    d_ph  = PH_WAIT;
                end
            end
            PH_ACTIVE: begin
                d_mode = OM_ZERO;
                if (!r_below) begin
                    d_we = 1'b1;
                    d_ph = PH_HOLD;
                end
            end
            PH_HOLD: begin
                d_mode = OM_ZERO;
                if (!r_below) begin
                    d_we = 1'b1;
                    if (r_ge) begin
                        d_cnt = '0;
                        d_ph  = PH_RELEASE;
                    end else begin
                        d_cnt = r_n;
                    end
                end
            end
            PH_RELEASE: begin
                d_we = 1'b1;
                if (r_ge) begin
                    d_cnt = '0;
                    d_ph  = PH_WAIT;
                end else begin
                    d_cnt  = r_n;
                    d_mode = OM_SCALE;
                end
            end
            default: ;
        endcase
        if (!in_range) begin
            d_we   = 1'b0;
            d_ph   = PH_WAIT;
            d_mode = OM_PASS;
        end
    end

    assign div_start = (r_state == S_DECIDE) && (d_mode == OM_SCALE);

    ng5p_gain_div #(
        .COUNT_BITS(COUNT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (d_num),
        .i_den   (d_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign prod = PW'(r_sample) * PW'($signed({1'b0, div_quot}));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_LOAD;
            S_LOAD:   n_state = S_DECIDE;
            S_DECIDE: n_state = (d_mode == OM_SCALE) ? S_DIV : S_OUT;
            S_DIV:    if (div_done) n_state = S_MUL;
            S_MUL:    n_state = S_OUT;
            S_OUT:    if (i_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int c = 0; c < CHANNELS; c++) begin
                r_phase[c] <= PH_WAIT;
                r_count[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if ((r_state == S_DECIDE) && d_we) begin
                r_phase[idx] <= d_ph;
                r_count[idx] <= d_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_ch     <= i_channel;
                r_sample <= i_sample_in;
            end
            S_LOAD: begin
                r_below <= (CMPW'(mag) <= CMPW'(r_threshold));
                r_ph    <= r_phase[idx];
                r_cnt   <= r_count[idx];
                r_n     <= cnt_next;
                r_ge    <= (cnt_next >= limit);
            end
            S_DECIDE: begin
                r_gph <= d_ph;
                r_y   <= (d_mode == OM_ZERO) ? '0 : r_sample;
            end
            S_MUL: begin
                r_y <= prod[GAIN_BITS +: SAMPLE_BITS];
            end
            default: ;
        endcase
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_sample_out = r_y;
    assign o_gate_phase = r_gph;

endmodule

// ----- hw/rtl/ng5p_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ng5p_checker
// Port-level checks on the noise gate, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ng5p_checker import ng5p_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic signed [SAMPLE_BITS-1:0] o_sample_out,
    input logic [PHASE_BITS-1:0]         o_gate_phase
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_out) && $stable(o_gate_phase))
        else $error("Result changed while the output transaction was stalled.");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_gate_phase == PH_WAIT || o_gate_phase == PH_ATTACK ||
                     o_gate_phase == PH_ACTIVE || o_gate_phase == PH_HOLD ||
                     o_gate_phase == PH_RELEASE))
        else $error("Reported gate phase is not a defined phase.");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("Input accepted again while a sample was in progress.");

    a_ready_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> o_ready && !o_valid)
        else $error("Gate did not return to idle after the output transaction.");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("Input ready while a result is still pending.");

endmodule

bind noise_gate_five_phase ng5p_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_ng5p_checker (.*);

// ----- sim/noise_gate_five_phase_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_gate_five_phase_tb
// Self-checking bench for the five-phase noise gate. A queue-fed driver
// offers channel/sample transactions while a clocked monitor predicts each
// gated sample and phase from its own per-channel gate state and compares
// every output transaction against the oldest prediction. Directed cases
// cover sample extremes, every phase, zero-length ramps and a ramp length
// shortened mid-ramp; random rounds then run quiet/loud bursts under many
// register settings with varying back-pressure.
// ----------------------------------------------------------------------------
module noise_gate_five_phase_tb import ng5p_pkg::*;;

    localparam int CHANNELS    = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 20;
    localparam int ROUNDS      = 12;
    localparam int ROUND_ITEMS = 155;
    localparam int LONG_STALL  = 400;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_IDX = '1;

    typedef struct {
        logic [CH_BITS-1:0]            ch;
        logic signed [SAMPLE_BITS-1:0] s;
    } t_gate_item;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [PHASE_BITS-1:0]         phase;
    } t_gate_result;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_ready;
    logic [CH_BITS-1:0]            i_channel   = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_in = '0;
    logic                          o_valid;
    logic                          i_ready     = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic [PHASE_BITS-1:0]         o_gate_phase;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      i_cfg_data  = '0;

    // Register copies and per-channel gate state, at their reset values.
    logic [THRESH_BITS-1:0] thr_reg  = '0;
    logic [COUNT_BITS-1:0]  wait_len = '0;
    logic [COUNT_BITS-1:0]  atk_len  = COUNT_BITS'(1);
    logic [COUNT_BITS-1:0]  hold_len = '0;
    logic [COUNT_BITS-1:0]  rel_len  = COUNT_BITS'(1);

    logic [PHASE_BITS-1:0] ch_phase [CHANNELS] = '{default: PH_WAIT};
    logic [COUNT_BITS-1:0] cnt_wait [CHANNELS] = '{default: '0};
    logic [COUNT_BITS-1:0] cnt_atk  [CHANNELS] = '{default: '0};
    logic [COUNT_BITS-1:0] cnt_hold [CHANNELS] = '{default: '0};
    logic [COUNT_BITS-1:0] cnt_rel  [CHANNELS] = '{default: '0};

    t_gate_item   sample_q[$];
    t_gate_result gated_q[$];

    int  queued_total   = 0;
    int  results_total  = 0;
    int  reg_writes     = 0;
    int  fail_count     = 0;
    int  tx_idle_pct    = 0;
    int  rx_idle_pct    = 0;
    int  stall_requests = 0;
    int  stall_served   = 0;
    int  stall_left     = 0;
    int  phase_hits [5] = '{default: 0};
    logic in_fire       = 1'b0;

    noise_gate_five_phase #(
        .CHANNELS   (CHANNELS),
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_channel   (i_channel),
        .i_sample_in (i_sample_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_sample_out(o_sample_out),
        .o_gate_phase(o_gate_phase),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [SAMPLE_BITS-1:0] ramp_scale(
        input logic signed [SAMPLE_BITS-1:0] s,
        input logic [GAIN_BITS-1:0]          g
    );
        logic signed [SAMPLE_BITS+GAIN_BITS:0] p;
        p = s * $signed({1'b0, g});
        return SAMPLE_BITS'(p >>> GAIN_BITS);
    endfunction

    function automatic t_gate_result gate_step(
        input logic [CH_BITS-1:0]            ch,
        input logic signed [SAMPLE_BITS-1:0] s
    );
        t_gate_result r;
        logic signed [SAMPLE_BITS:0] sx;
        logic [SAMPLE_BITS:0] mag;
        logic quiet;
        logic [COUNT_BITS-1:0] n;
        sx = s;
        mag = (sx < 0) ? -sx : sx;
        quiet = (mag <= {1'b0, thr_reg});
        r.sample = s;
        case (ch_phase[ch])
            PH_WAIT: begin
                if (quiet) begin
                    n = cnt_wait[ch] + 1'b1;
                    if (n >= wait_len) begin
                        n = '0;
                        ch_phase[ch] = PH_ATTACK;
                    end
                    cnt_wait[ch] = n;
                end else begin
                    cnt_wait[ch] = '0;
                end
            end
            PH_ATTACK: begin
                if (quiet) begin
                    n = cnt_atk[ch] + 1'b1;
                    if (n >= atk_len) begin
                        cnt_atk[ch] = '0;
                        ch_phase[ch] = PH_ACTIVE;
                        r.sample = '0;
                    end else begin
                        cnt_atk[ch] = n;
                        r.sample = ramp_scale(s, GAIN_BITS'({atk_len - n, {GAIN_BITS{1'b0}}}
                                                  / {{GAIN_BITS{1'b0}}, atk_len}));
                    end
                end else begin
                    cnt_atk[ch] = '0;
                    ch_phase[ch] = PH_WAIT;
                end
            end
            PH_ACTIVE: begin
                if (!quiet) begin
                    ch_phase[ch] = PH_HOLD;
                end
                r.sample = '0;
            end
            PH_HOLD: begin
                if (!quiet) begin
                    n = cnt_hold[ch] + 1'b1;
                    if (n >= hold_len) begin
                        n = '0;
                        ch_phase[ch] = PH_RELEASE;
                    end
                    cnt_hold[ch] = n;
                end
                r.sample = '0;
            end
            PH_RELEASE: begin
                n = cnt_rel[ch] + 1'b1;
                if (n >= rel_len) begin
                    cnt_rel[ch] = '0;
                    ch_phase[ch] = PH_WAIT;
                end else begin
                    cnt_rel[ch] = n;
                    r.sample = ramp_scale(s, GAIN_BITS'({n, {GAIN_BITS{1'b0}}}
                                              / {{GAIN_BITS{1'b0}}, rel_len}));
                end
            end
            default: begin
            end
        endcase
        r.phase = ch_phase[ch];
        return r;
    endfunction

    // Input driver: a new transaction is taken from the queue only once the
    // previous one has been accepted.
    always @(negedge i_clk) begin : drive_samples
        t_gate_item next_in;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (sample_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_in = sample_q.pop_front();
                i_valid <= 1'b1;
                i_channel <= next_in.ch;
                i_sample_in <= next_in.s;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (stall_served != stall_requests) begin
            stall_served = stall_served + 1;
            stall_left = LONG_STALL;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_gate_result want;
        in_fire <= i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                gated_q.push_back(gate_step(i_channel, i_sample_in));
            end
            if (o_valid && i_ready) begin
                results_total = results_total + 1;
                if (o_gate_phase <= PH_RELEASE) begin
                    phase_hits[o_gate_phase] = phase_hits[o_gate_phase] + 1;
                end
                if (gated_q.size() == 0) begin
                    $error("Output transaction with no sample pending: sample_out %0d",
                           o_sample_out);
                    fail_count = fail_count + 1;
                end else begin
                    want = gated_q.pop_front();
                    if (o_sample_out !== want.sample) begin
                        $error("sample_out mismatch: expected %0d, got %0d",
                               want.sample, o_sample_out);
                        fail_count = fail_count + 1;
                    end
                    if (o_gate_phase !== want.phase) begin
                        $error("gate_phase mismatch: expected %0d, got %0d",
                               want.phase, o_gate_phase);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    task automatic offer(input int ch, input int value);
        t_gate_item t;
        t.ch = CH_BITS'(ch);
        t.s = SAMPLE_BITS'(value);
        sample_q.push_back(t);
        queued_total = queued_total + 1;
    endtask

    task automatic drain_results();
        while (results_total < queued_total) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_THRESHOLD: thr_reg = data[THRESH_BITS-1:0];
            CFG_WAIT:      wait_len = data[COUNT_BITS-1:0];
            CFG_ATTACK:    atk_len = data[COUNT_BITS-1:0];
            CFG_HOLD:      hold_len = data[COUNT_BITS-1:0];
            CFG_RELEASE:   rel_len = data[COUNT_BITS-1:0];
            default: begin
            end
        endcase
        reg_writes = reg_writes + 1;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input int thr, input int wt, input int atk,
                             input int hld, input int rel);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_WAIT, wt);
        write_reg(CFG_ATTACK, atk);
        write_reg(CFG_HOLD, hld);
        write_reg(CFG_RELEASE, rel);
    endtask

    function automatic int quiet_level();
        int mag;
        mag = ($urandom_range(3) == 0) ? int'(thr_reg) : $urandom_range(int'(thr_reg));
        if ($urandom_range(1)) begin
            return -mag;
        end
        return (mag > 32767) ? 32767 : mag;
    endfunction

    function automatic int loud_level();
        int mag;
        if (thr_reg >= 32768) begin
            return quiet_level();
        end
        mag = ($urandom_range(3) == 0) ? int'(thr_reg) + 1
                                       : $urandom_range(32768, int'(thr_reg) + 1);
        if (mag == 32768 || $urandom_range(1)) begin
            return -mag;
        end
        return mag;
    endfunction

    // Alternating quiet and loud bursts per channel walk the gate through
    // its phases; some transactions go to other channels or carry noise.
    task automatic gen_round(input int count);
        int made;
        int ch;
        int len;
        bit loud;
        made = 0;
        loud = 1'b0;
        while (made < count) begin
            ch = $urandom_range(CHANNELS - 1);
            len = loud ? $urandom_range(1, 12) : $urandom_range(1, 24);
            for (int k = 0; k < len && made < count; k++) begin
                if ($urandom_range(9) == 0) begin
                    offer($urandom_range(CHANNELS - 1), $urandom_range(65535));
                end else begin
                    offer(($urandom_range(4) == 0) ? $urandom_range(CHANNELS - 1) : ch,
                          loud ? loud_level() : quiet_level());
                end
                made = made + 1;
            end
            loud = !loud;
        end
    endtask

    initial begin
        tx_idle_pct = 7;
        rx_idle_pct = 78;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero wait and hold, unit ramps, full-scale samples.
        offer(0, 0);
        offer(0, 0);
        offer(0, -32768);
        offer(0, 32767);
        offer(0, -32768);
        offer(7, 32767);
        offer(7, -1);
        drain_results();

        write_all(1000, 1, 4, 1, 3);
        for (int k = int'(CFG_RELEASE) + 1; k <= int'(CFG_LAST_IDX); k++) begin
            write_reg(CFG_IDX_BITS'(k), 7);
        end
        offer(3, 500);
        offer(3, -1000);
        offer(3, 999);
        offer(3, -7);
        drain_results();

        // Shorten the attack ramp while channel 3 is partway down it.
        write_reg(CFG_ATTACK, 2);
        offer(3, 1);
        offer(3, 1001);
        offer(3, -32768);
        offer(3, 32767);
        offer(3, -32768);
        offer(3, 0);
        offer(4, 0);
        offer(4, -1001);
        drain_results();

        // Zero-length wait, ramps and hold.
        write_all(1000, 0, 0, 0, 0);
        offer(5, 1000);
        offer(5, -1000);
        offer(5, 1001);
        offer(5, 2000);
        offer(5, 12345);
        drain_results();

        for (int r = 0; r < ROUNDS; r++) begin
            if (r < 4) begin
                tx_idle_pct = 7;
                rx_idle_pct = 78;
            end else if (r < 8) begin
                tx_idle_pct = 78;
                rx_idle_pct = 7;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (r)
                1: write_all(32768, 0, int'(COUNT_MAX), 0, int'(COUNT_MAX));
                5: write_all(0, int'(COUNT_MAX), 1, int'(COUNT_MAX), 1);
                9: write_all(0, 0, 0, 0, 0);
                default: begin
                    case ($urandom_range(3))
                        0: write_reg(CFG_THRESHOLD, $urandom_range(32768));
                        1: write_reg(CFG_THRESHOLD, $urandom_range(300));
                        2: write_reg(CFG_THRESHOLD, $urandom_range(4000));
                        default: write_reg(CFG_THRESHOLD, $urandom_range(16000));
                    endcase
                    write_reg(CFG_WAIT, $urandom_range(6));
                    write_reg(CFG_ATTACK, $urandom_range(10));
                    write_reg(CFG_HOLD, $urandom_range(5));
                    write_reg(CFG_RELEASE, $urandom_range(10));
                end
            endcase
            if (r == 2 || r == 6) begin
                stall_requests = stall_requests + 1;
            end
            gen_round(ROUND_ITEMS);
            drain_results();
        end

        repeat (40) @(posedge i_clk);
        if (gated_q.size() != 0) begin
            $error("%0d predicted samples never came out", gated_q.size());
            fail_count = fail_count + 1;
        end
        $display("Checked %0d gated samples across %0d register writes, long output stalls",
                 results_total, reg_writes);
        $display("and drained pauses. Phases seen: %0d %0d %0d %0d %0d (wait to release).",
                 phase_hits[PH_WAIT], phase_hits[PH_ATTACK], phase_hits[PH_ACTIVE],
                 phase_hits[PH_HOLD], phase_hits[PH_RELEASE]);
        if (fail_count == 0) begin
            $display("noise_gate_five_phase_tb passed");
        end else begin
            $display("noise_gate_five_phase_tb failed");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("noise_gate_five_phase_tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/ng5p_pkg.sv
hw/rtl/ng5p_gain_div.sv
hw/rtl/noise_gate_five_phase.sv
hw/rtl/ng5p_checker.sv
sim/noise_gate_five_phase_tb.sv
